// File: rtl/core/baa_pkg.sv
// Package for the bump-pointer arena allocator.
// Holds widths, request and status codes, and the transaction structs.
// No dependencies.
package baa_pkg;

  // Field widths fixed by the request and result formats
  localparam int DATA_W  = 32;
  localparam int TYPE_W  = 3;
  localparam int ALIGN_W = 4;
  localparam int STAT_W  = 3;

  // Address space and scratch stack sizing
  localparam int ADDR_W      = 32;
  localparam int SCR_DEPTH   = 8;
  localparam int SCR_IDX_W   = (SCR_DEPTH > 1) ? $clog2(SCR_DEPTH) : 1;
  localparam int SCR_CNT_W   = $clog2(SCR_DEPTH + 1);

  // Exact sums: base + fill + alignment slack + size never wrap
  localparam int SUM_W = (ADDR_W > DATA_W + 2) ? ADDR_W + 1 : DATA_W + 3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_SIZE = 1'd1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ALLOC       = 3'd0,
    REQ_ZALLOC      = 3'd1,
    REQ_REALLOC     = 3'd2,
    REQ_CLEAR       = 3'd3,
    REQ_SCR_OPEN    = 3'd4,
    REQ_SCR_CLOSE   = 3'd5
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_OOM       = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_FREE      = 3'd4,
    ST_EXCEEDS   = 3'd5,
    ST_OVERFLOW  = 3'd6,
    ST_UNDERFLOW = 3'd7
  } status_t;

  // One request transaction
  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [DATA_W-1:0]  req_size;
    logic [ALIGN_W-1:0] align_log2;
    logic [DATA_W-1:0]  block_addr;
    logic [DATA_W-1:0]  current_size;
  } req_t;

  // One result transaction
  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  result_addr;
    logic [DATA_W-1:0]  copy_len;
    logic               zero_fill;
    logic [DATA_W-1:0]  fill_level;
  } rsp_t;

  // Scratch stack control from the datapath
  typedef struct packed {
    logic push;
    logic pop;
  } stk_op_t;

endpackage

// File: rtl/core/baa_calc.sv
// Combinational request evaluation for the bump-pointer arena allocator.
// Computes the result, the next fill offset and the scratch stack operation.
// Depends on baa_pkg.
module baa_calc import baa_pkg::*; (
  input  req_t                  req,
  input  logic [DATA_W-1:0]     arena_base,
  input  logic [DATA_W-1:0]     arena_size,
  input  logic [DATA_W-1:0]     fill,
  input  logic [SCR_CNT_W-1:0]  scr_cnt,
  input  logic [DATA_W-1:0]     scr_top,
  output rsp_t                  rsp,
  output logic [DATA_W-1:0]     fill_nxt,
  output stk_op_t               stk_op
);

  localparam logic [SUM_W-1:0] ADDR_LIMIT = SUM_W'(1) << ADDR_W;

  logic [SUM_W-1:0] base_x, size_x, fill_x, rsz_x, cur_x, blk_x;
  logic [SUM_W-1:0] top_x, used_x, align_m1, start_x, bend_x, ip_end_x;
  logic             bump_empty, bump_fit, ip_fit;
  status_t          bump_st;
  logic [DATA_W-1:0] bump_addr, bump_fill;

  // Shared bump datapath: round up, add size, check capacity
  always_comb begin
    base_x   = SUM_W'(arena_base);
    size_x   = SUM_W'(arena_size);
    fill_x   = SUM_W'(fill);
    rsz_x    = SUM_W'(req.req_size);
    cur_x    = SUM_W'(req.current_size);
    blk_x    = SUM_W'(req.block_addr);
    top_x    = base_x + size_x;
    used_x   = base_x + fill_x;
    align_m1 = (SUM_W'(1) << req.align_log2) - SUM_W'(1);
    start_x  = (used_x + align_m1) & ~align_m1;
    bend_x   = start_x + rsz_x;
    ip_end_x = blk_x + rsz_x;

    bump_empty = (req.req_size == '0) || (arena_size == '0);
    bump_fit   = !(bend_x > top_x) && !(bend_x > ADDR_LIMIT);
    ip_fit     = !(ip_end_x > top_x) && !(ip_end_x > ADDR_LIMIT);

    if (bump_empty) begin
      bump_st = ST_EMPTY;
    end else if (!bump_fit) begin
      bump_st = ST_OOM;
    end else begin
      bump_st = ST_OK;
    end
    bump_addr = (bump_st == ST_OK) ? start_x[DATA_W-1:0] : '0;
    bump_fill = (bump_st == ST_OK) ? DATA_W'(bend_x - base_x) : fill;
  end

  // Request decode
  always_comb begin
    rsp.status      = ST_OK;
    rsp.result_addr = '0;
    rsp.copy_len    = '0;
    rsp.zero_fill   = 1'b0;
    fill_nxt        = fill;
    stk_op          = '0;

    unique case (req.req_type)
      REQ_ALLOC: begin
        rsp.status      = bump_st;
        rsp.result_addr = bump_addr;
        fill_nxt        = bump_fill;
      end
      REQ_ZALLOC: begin
        rsp.status      = bump_st;
        rsp.result_addr = bump_addr;
        rsp.zero_fill   = (bump_st == ST_OK);
        fill_nxt        = bump_fill;
      end
      REQ_REALLOC: begin
        priority if (arena_size == '0 || arena_base == '0 || req.req_size == '0) begin
          rsp.status = ST_EMPTY;
        end else if (req.block_addr == '0 || req.current_size == '0) begin
          // no old block: plain allocation
          rsp.status      = bump_st;
          rsp.result_addr = bump_addr;
          fill_nxt        = bump_fill;
        end else if (blk_x < base_x || blk_x >= top_x) begin
          rsp.status = ST_OUTSIDE;
        end else if (blk_x >= used_x) begin
          rsp.status = ST_FREE;
        end else if (cur_x > fill_x) begin
          rsp.status = ST_EXCEEDS;
        end else if (blk_x == used_x - cur_x) begin
          // last block: resize in place
          if (ip_fit) begin
            rsp.result_addr = req.block_addr;
            fill_nxt        = DATA_W'(ip_end_x - base_x);
          end else begin
            rsp.status = ST_OOM;
          end
        end else begin
          // move: new zeroed block, caller copies the overlap
          rsp.status      = bump_st;
          rsp.result_addr = bump_addr;
          fill_nxt        = bump_fill;
          if (bump_st == ST_OK) begin
            rsp.zero_fill = 1'b1;
            rsp.copy_len  = (req.current_size < req.req_size) ?
                            req.current_size : req.req_size;
          end
        end
      end
      REQ_CLEAR: begin
        fill_nxt = '0;
      end
      REQ_SCR_OPEN: begin
        if (scr_cnt >= SCR_CNT_W'(SCR_DEPTH)) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          stk_op.push = 1'b1;
        end
      end
      REQ_SCR_CLOSE: begin
        if (scr_cnt == '0) begin
          rsp.status = ST_UNDERFLOW;
        end else begin
          stk_op.pop = 1'b1;
          fill_nxt   = scr_top;
        end
      end
      default: begin
        // undefined request codes are ignored
      end
    endcase

    rsp.fill_level = fill_nxt;
  end

endmodule

// File: rtl/core/bump_arena_allocator_unit.sv
// Top level of the bump-pointer arena allocator: request register, fill and
// scratch stack state, and result register. Depends on baa_pkg and baa_calc.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | req_type, req_size, align_log2,
//           |           |                     | block_addr, current_size
//   out_    | output    | out_valid/out_stall | status, result_addr, copy_len,
//           |           |                     | zero_fill, fill_level
//   cfg_    | input     | cfg_wr_en           | cfg_idx, cfg_wdata
//
// One request per cycle sustained while out_stall is low (request register, then
// result register). The fill register update sits in the same single pass, so
// back-to-back requests see each other's fill. Synchronous active-low reset
// clears fill, scratch count, arena registers and valids. A stalled result
// holds the result register and the request register, with in_stall raised.
module bump_arena_allocator_unit import baa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TYPE_W-1:0]    in_req_type,
  input  logic [DATA_W-1:0]    in_req_size,
  input  logic [ALIGN_W-1:0]   in_align_log2,
  input  logic [DATA_W-1:0]    in_block_addr,
  input  logic [DATA_W-1:0]    in_current_size,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    out_status,
  output logic [DATA_W-1:0]    out_result_addr,
  output logic [DATA_W-1:0]    out_copy_len,
  output logic                 out_zero_fill,
  output logic [DATA_W-1:0]    out_fill_level,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  logic                 s1_vld_r, s1_vld_nxt;
  req_t                 s1_req_r;
  logic                 out_vld_r, out_vld_nxt;
  rsp_t                 out_rsp_r;
  logic [DATA_W-1:0]    base_r, size_r;
  logic [DATA_W-1:0]    fill_r;
  logic [SCR_CNT_W-1:0] cnt_r;
  logic [DATA_W-1:0]    stk_r [SCR_DEPTH];

  logic                 in_acc, adv;
  logic [SCR_IDX_W-1:0] top_idx;
  logic [DATA_W-1:0]    scr_top;
  rsp_t                 rsp;
  logic [DATA_W-1:0]    fill_nxt;
  stk_op_t              stk_op;

  // Handshake: request stage advances when the result register is free
  assign adv      = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = in_acc ? 1'b1 : (adv ? 1'b0 : s1_vld_r);
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // Top of the scratch stack
  assign top_idx = SCR_IDX_W'(cnt_r - SCR_CNT_W'(1));
  assign scr_top = stk_r[top_idx];

  baa_calc u_calc (
    .req        (s1_req_r),
    .arena_base (base_r),
    .arena_size (size_r),
    .fill       (fill_r),
    .scr_cnt    (cnt_r),
    .scr_top    (scr_top),
    .rsp        (rsp),
    .fill_nxt   (fill_nxt),
    .stk_op     (stk_op)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      fill_r    <= '0;
      cnt_r     <= '0;
      base_r    <= '0;
      size_r    <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        fill_r <= fill_nxt;
        if (stk_op.push) begin
          cnt_r <= cnt_r + SCR_CNT_W'(1);
        end else if (stk_op.pop) begin
          cnt_r <= cnt_r - SCR_CNT_W'(1);
        end
      end
      if (cfg_wr_en) begin
        unique case (cfg_idx)
          CFG_ARENA_BASE: base_r <= cfg_wdata;
          CFG_ARENA_SIZE: size_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers and scratch stack storage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= '{req_type:     in_req_type,
                    req_size:     in_req_size,
                    align_log2:   in_align_log2,
                    block_addr:   in_block_addr,
                    current_size: in_current_size};
    end
    if (adv) begin
      out_rsp_r <= rsp;
    end
    if (adv && stk_op.push) begin
      stk_r[cnt_r[SCR_IDX_W-1:0]] <= fill_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_status      = out_rsp_r.status;
  assign out_result_addr = out_rsp_r.result_addr;
  assign out_copy_len    = out_rsp_r.copy_len;
  assign out_zero_fill   = out_rsp_r.zero_fill;
  assign out_fill_level  = out_rsp_r.fill_level;

`ifndef SYNTHESIS
  // scratch count stays within the stack
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SCR_CNT_W'(SCR_DEPTH))
    else $error("scratch count past stack depth");

  // fill moves only when a request passes through
  a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(fill_r))
    else $error("fill changed without a request");

  // a zero-fill grant is always a successful one
  a_zf_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_fill |-> out_status == ST_OK)
    else $error("zero fill on failed request");

  // a copy length only comes with a moved, zeroed block
  a_copy_zf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_copy_len != '0 |-> out_zero_fill)
    else $error("copy length without moved block");

  // the fill level reported matches the fill register just written
  a_fill_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_fill_level == fill_r)
    else $error("reported fill differs from state");
`endif

endmodule
